@@ rtl/srm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types, widths and helpers for the step response metrics block.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned ERR_W  = 17;
  localparam int unsigned RES_W  = 24;
  localparam logic [RES_W-1:0] SAT24 = 24'hFF_FFFF;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // Division job codes, run in this order
  typedef enum logic [2:0] {
    DS_OS_L  = 3'd0,
    DS_OS_R  = 3'd1,
    DS_ERR_L = 3'd2,
    DS_ERR_R = 3'd3,
    DS_SYNC  = 3'd4
  } div_sel_e;

  // Magnitude of a 16-bit signed value
  function automatic logic [SPD_W-1:0] mag16(input logic signed [SPD_W-1:0] v);
    logic [SPD_W-1:0] r;
    r = v[SPD_W-1] ? SPD_W'(-v) : SPD_W'(v);
    return r;
  endfunction

  // Magnitude of a 17-bit signed value
  function automatic logic [ERR_W-1:0] mag17(input logic signed [ERR_W-1:0] v);
    logic [ERR_W-1:0] r;
    r = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    return r;
  endfunction

endpackage

@@ rtl/step_response_metrics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_response_metrics
// Step test analyzer: stores samples, then walks them to produce metrics.
// ----------------------------------------------------------------------------
// A sample that is not the last one is taken by a single write into the sample
// memories, and busy stays low. On the last sample busy rises and the block
// walks the stored samples through the memory read port, one sample a cycle,
// then runs five divisions on a shared bit-serial divider (its quotient width
// DVW is 34 at the default depth), and drives the result for one cycle on
// valid_o. The receiver cannot stall a result; busy is low again in the cycle
// the result appears.
module step_response_metrics import srm_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [TIME_W-1:0]          sample_time_i,
  input  logic signed [SPD_W-1:0]    target_left_i,
  input  logic signed [SPD_W-1:0]    target_right_i,
  input  logic signed [SPD_W-1:0]    speed_left_i,
  input  logic signed [SPD_W-1:0]    speed_right_i,
  input  logic                       last_sample_i,
  output logic                       valid_o,
  output logic [TIME_W-1:0]          settle_left_o,
  output logic [TIME_W-1:0]          settle_right_o,
  output logic [RES_W-1:0]           excess_left_o,
  output logic [RES_W-1:0]           excess_right_o,
  output logic [RES_W-1:0]           steady_err_left_o,
  output logic [RES_W-1:0]           steady_err_right_o,
  output logic [TIME_W-1:0]          rise_left_o,
  output logic [TIME_W-1:0]          rise_right_o,
  output logic [RES_W-1:0]           sync_error_o
);

  localparam int unsigned AW   = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = CW + ERR_W;
  localparam int unsigned DVW  = (SUMW + 8 > 32) ? SUMW + 8 : 32;
  localparam int unsigned DSW  = (CW > SPD_W) ? CW : SPD_W;

  state_e state_q;
  div_sel_e div_sel_q;

  // Sample memories
  logic [TIME_W-1:0]    time_mem  [MAX_SAMPLES];
  logic [2*SPD_W-1:0]   speed_mem [MAX_SAMPLES];
  logic [2*ERR_W-1:0]   err_mem   [MAX_SAMPLES];
  logic [TIME_W-1:0]    rd_time_q;
  logic [2*SPD_W-1:0]   rd_speed_q;
  logic [2*ERR_W-1:0]   rd_err_q;

  // Fill tracking
  logic [CW-1:0] count_q, ten_q, n_q, num_q;
  logic [3:0]    mod_q;
  logic [CW-1:0] n_next, ten_next;
  logic [3:0]    mod_next;
  logic          cnt_inc, accept;
  logic [AW-1:0] slot;

  // Test-wide captures
  logic signed [SPD_W-1:0] fin_q [2];
  logic signed [SPD_W-1:0] tgt_q [2];
  logic [TIME_W-1:0]       last_time_q;

  // Walk control
  logic [CW-1:0] rd_idx_q, p_idx_q;
  logic          rd_en, p_vld_q;

  // Per channel accumulators
  logic [TIME_W-1:0] settle_q [2];
  logic [SPD_W-1:0]  peak_q   [2];
  logic              f10_q    [2];
  logic              f90_q    [2];
  logic [TIME_W-1:0] t10_q    [2];
  logic [TIME_W-1:0] t90_q    [2];
  logic [SUMW-1:0]   esum_q   [2];
  logic [SUMW-1:0]   ssum_q;

  // Divider hookup
  logic           div_start_q, div_done;
  logic [DVW-1:0] div_dvd, div_quot;
  logic [DSW-1:0] div_dvs;
  logic [RES_W-1:0] q_sat;

  // Result registers
  logic              valid_q;
  logic [TIME_W-1:0] settle_out_q [2];
  logic [TIME_W-1:0] rise_out_q   [2];
  logic [RES_W-1:0]  os_q  [2];
  logic [RES_W-1:0]  err_q [2];
  logic [RES_W-1:0]  sync_q;

  logic [SPD_W-1:0]  amag [2];
  logic              os_zero [2];

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Next fill count, saturating at the depth
  assign cnt_inc  = count_q < CW'(MAX_SAMPLES);
  assign n_next   = cnt_inc ? count_q + 1'b1 : count_q;
  assign mod_next = (cnt_inc && mod_q == 4'd9) ? 4'd0 : (cnt_inc ? mod_q + 4'd1 : mod_q);
  assign ten_next = (cnt_inc && mod_q == 4'd9) ? ten_q + 1'b1 : ten_q;
  assign slot     = cnt_inc ? count_q[AW-1:0] : AW'(MAX_SAMPLES - 1);

  // Write the memories on a sample transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_mem[slot]  <= sample_time_i;
      speed_mem[slot] <= {speed_right_i, speed_left_i};
      err_mem[slot]   <= {ERR_W'({target_right_i[SPD_W-1], target_right_i}
                                 - {speed_right_i[SPD_W-1], speed_right_i}),
                          ERR_W'({target_left_i[SPD_W-1], target_left_i}
                                 - {speed_left_i[SPD_W-1], speed_left_i})};
    end
  end

  // Read port; the walk starts after the final write, so no forwarding is needed
  assign rd_en = (state_q == ST_WALK) && (rd_idx_q < n_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_time_q  <= time_mem[rd_idx_q[AW-1:0]];
      rd_speed_q <= speed_mem[rd_idx_q[AW-1:0]];
      rd_err_q   <= err_mem[rd_idx_q[AW-1:0]];
    end
  end

  // Divider operands
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      amag[c]    = mag16(tgt_q[c]);
      os_zero[c] = (amag[c] == '0) || (peak_q[c] <= amag[c]);
    end
    div_dvd = '0;
    div_dvs = '0;
    unique case (div_sel_q)
      DS_OS_L: begin
        div_dvd = DVW'({SPD_W'(peak_q[0] - amag[0]), 16'h0});
        div_dvs = DSW'(amag[0]);
      end
      DS_OS_R: begin
        div_dvd = DVW'({SPD_W'(peak_q[1] - amag[1]), 16'h0});
        div_dvs = DSW'(amag[1]);
      end
      DS_ERR_L: begin
        div_dvd = DVW'({esum_q[0], 8'h0});
        div_dvs = DSW'(num_q);
      end
      DS_ERR_R: begin
        div_dvd = DVW'({esum_q[1], 8'h0});
        div_dvs = DSW'(num_q);
      end
      DS_SYNC: begin
        div_dvd = DVW'({ssum_q, 8'h0});
        div_dvs = DSW'(n_q);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  assign q_sat = (div_quot > DVW'(SAT24)) ? SAT24 : div_quot[RES_W-1:0];

  srm_div #(
    .NW(DVW),
    .DW(DSW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Control: load, walk, divide, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ten_q       <= '0;
      mod_q       <= '0;
      n_q         <= '0;
      num_q       <= '0;
      rd_idx_q    <= '0;
      p_vld_q     <= 1'b0;
      p_idx_q     <= '0;
      div_sel_q   <= DS_OS_L;
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        tgt_q[c] <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      p_vld_q     <= rd_en;
      p_idx_q     <= rd_idx_q;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            tgt_q[0] <= target_left_i;
            tgt_q[1] <= target_right_i;
            if (last_sample_i) begin
              n_q      <= n_next;
              num_q    <= (ten_next == '0) ? CW'(1) : ten_next;
              count_q  <= '0;
              ten_q    <= '0;
              mod_q    <= '0;
              rd_idx_q <= '0;
              state_q  <= ST_WALK;
            end else begin
              count_q <= n_next;
              ten_q   <= ten_next;
              mod_q   <= mod_next;
            end
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (p_vld_q && p_idx_q == n_q - 1'b1) begin
            div_sel_q   <= DS_OS_L;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (div_sel_q == DS_SYNC) begin
              state_q <= ST_OUT;
            end else begin
              div_sel_q   <= div_sel_e'(div_sel_q + 3'd1);
              div_start_q <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: captures, per-sample update, division results, outputs
  always_ff @(posedge clk_i) begin
    logic signed [SPD_W-1:0] s;
    logic signed [ERR_W-1:0] e;
    logic [SPD_W-1:0]        sm;
    logic [ERR_W-1:0]        dm;
    if (accept && last_sample_i) begin
      fin_q[0]    <= speed_left_i;
      fin_q[1]    <= speed_right_i;
      last_time_q <= sample_time_i;
      ssum_q      <= '0;
      for (int c = 0; c < 2; c++) begin
        peak_q[c] <= '0;
        f10_q[c]  <= 1'b0;
        f90_q[c]  <= 1'b0;
        esum_q[c] <= '0;
      end
    end
    // Fold one sample into the accumulators
    if (p_vld_q && state_q == ST_WALK) begin
      ssum_q <= ssum_q + SUMW'(mag17(ERR_W'({rd_speed_q[SPD_W-1], rd_speed_q[SPD_W-1:0]})
                - ERR_W'({rd_speed_q[2*SPD_W-1], rd_speed_q[2*SPD_W-1:SPD_W]})));
      for (int c = 0; c < 2; c++) begin
        s  = rd_speed_q[c*SPD_W +: SPD_W];
        e  = rd_err_q[c*ERR_W +: ERR_W];
        sm = mag16(s);
        dm = mag17(ERR_W'({s[SPD_W-1], s}) - ERR_W'({fin_q[c][SPD_W-1], fin_q[c]}));
        if (p_idx_q == '0 || 22'(dm) * 22'd20 > 22'(mag16(fin_q[c]))) begin
          settle_q[c] <= rd_time_q;
        end
        if (sm > peak_q[c]) begin
          peak_q[c] <= sm;
        end
        if (!f90_q[c]) begin
          if (!f10_q[c] && 20'(sm) * 20'd10 >= 20'(amag[c])) begin
            f10_q[c] <= 1'b1;
            t10_q[c] <= rd_time_q;
          end
          if (20'(sm) * 20'd10 >= 20'(amag[c]) * 20'd9) begin
            f90_q[c] <= 1'b1;
            t90_q[c] <= rd_time_q;
          end
        end
        if (p_idx_q >= n_q - num_q) begin
          esum_q[c] <= esum_q[c] + SUMW'(mag17(e));
        end
      end
    end
    // Store division results
    if (state_q == ST_DIV && div_done) begin
      case (div_sel_q)
        DS_OS_L:  os_q[0]  <= os_zero[0] ? '0 : q_sat;
        DS_OS_R:  os_q[1]  <= os_zero[1] ? '0 : q_sat;
        DS_ERR_L: err_q[0] <= q_sat;
        DS_ERR_R: err_q[1] <= q_sat;
        DS_SYNC:  sync_q   <= q_sat;
        default:  sync_q   <= q_sat;
      endcase
    end
    // Resolve time metrics and special cases
    if (state_q == ST_OUT) begin
      for (int c = 0; c < 2; c++) begin
        settle_out_q[c] <= (n_q < CW'(2) || fin_q[c] == '0) ? last_time_q : settle_q[c];
        if (amag[c] == '0) begin
          rise_out_q[c] <= '0;
        end else if (f10_q[c] && f90_q[c]) begin
          rise_out_q[c] <= (t90_q[c] >= t10_q[c]) ? t90_q[c] - t10_q[c] : '0;
        end else begin
          rise_out_q[c] <= last_time_q;
        end
      end
    end
  end

  assign valid_o            = valid_q;
  assign settle_left_o      = settle_out_q[0];
  assign settle_right_o     = settle_out_q[1];
  assign excess_left_o      = os_q[0];
  assign excess_right_o     = os_q[1];
  assign steady_err_left_o  = err_q[0];
  assign steady_err_right_o = err_q[1];
  assign rise_left_o        = rise_out_q[0];
  assign rise_right_o       = rise_out_q[1];
  assign sync_error_o       = sync_q;

  // The last sample always starts an analysis
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_sample_i) |=> busy)
    else $error("last sample did not start analysis");

  // One result per test
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result repeated");

  // The walk never reads past the stored samples
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rd_idx_q <= n_q && n_q != '0))
    else $error("walk index out of range");

  // Fill count never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("fill count overflow");

endmodule

@@ rtl/srm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srm_div import srm_pkg::*; #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_q, div_q;
  logic [NW-1:0]   quo_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial;
  logic            fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
